@@ design/kmer_window_counter_unit_macros.svh @@
// Assertion helpers for the k-mer counter.
// Both expect clk and arst_n in the scope of use.
`ifndef KMER_WINDOW_COUNTER_UNIT_MACROS_SVH
`define KMER_WINDOW_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication
`define KWC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kmer_window_counter_unit: check failed");

// Next-cycle implication
`define KWC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kmer_window_counter_unit: check failed");

`endif

@@ design/kwc_pkg.sv @@
package kwc_pkg;

	// Fixed field widths
	localparam int SLOT_W  = 10;
	localparam int CODE_W  = 50;
	localparam int COUNT_W = 32;
	localparam int TOTAL_W = 11;

	// Character codes of the four bases
	localparam logic [7:0] CHAR_A = 8'h41;
	localparam logic [7:0] CHAR_C = 8'h43;
	localparam logic [7:0] CHAR_G = 8'h47;
	localparam logic [7:0] CHAR_T = 8'h54;

	typedef enum logic [1:0] {
		REQ_ADD  = 2'd0,
		REQ_EOR  = 2'd1,
		REQ_READ = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SLOT,
		ST_FIN
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic issue;
		logic hit_wr;
		logic miss_wr;
		logic slot_cap;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic scan_go;
		logic slot_go;
		logic hit;
		logic scan_end;
	} sts_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_dec_t;

	// A=0 C=1 G=2 T=3; anything else (N, lower case) is not a base
	function automatic base_dec_t decode_base(input logic [7:0] ch);
		base_dec_t d;
		d.ok   = 1'b1;
		d.code = 2'd0;
		unique case (ch)
			CHAR_A: d.code = 2'd0;
			CHAR_C: d.code = 2'd1;
			CHAR_G: d.code = 2'd2;
			CHAR_T: d.code = 2'd3;
			default: d.ok = 1'b0;
		endcase
		return d;
	endfunction

endpackage

@@ design/kwc_ctrl.sv @@
module kwc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  kwc_pkg::sts_t sts,
	output kwc_pkg::cmd_t cmd
);

	kwc_pkg::state_t state_q;
	kwc_pkg::state_t state_d;
	logic            out_vld_q;
	logic            out_free;

	assign out_free  = !out_vld_q || !out_stall;
	assign out_valid = out_vld_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kwc_pkg::ST_IDLE: begin
				if (in_valid) begin
					priority if (sts.scan_go) state_d = kwc_pkg::ST_SCAN;
					else if (sts.slot_go)     state_d = kwc_pkg::ST_SLOT;
					else                      state_d = kwc_pkg::ST_FIN;
				end
			end
			kwc_pkg::ST_SCAN: begin
				if (sts.hit || sts.scan_end) state_d = kwc_pkg::ST_FIN;
			end
			kwc_pkg::ST_SLOT: state_d = kwc_pkg::ST_FIN;
			kwc_pkg::ST_FIN: begin
				if (out_free) state_d = kwc_pkg::ST_IDLE;
			end
			default: state_d = kwc_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd          = '0;
		in_stall     = (state_q != kwc_pkg::ST_IDLE);
		cmd.accept   = (state_q == kwc_pkg::ST_IDLE) && in_valid;
		cmd.issue    = (state_q == kwc_pkg::ST_SCAN) && !sts.hit && !sts.scan_end;
		cmd.hit_wr   = (state_q == kwc_pkg::ST_SCAN) && sts.hit;
		cmd.miss_wr  = (state_q == kwc_pkg::ST_SCAN) && sts.scan_end;
		cmd.slot_cap = (state_q == kwc_pkg::ST_SLOT);
		cmd.load_out = (state_q == kwc_pkg::ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kwc_pkg::ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)   out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
		end
	end

endmodule

@@ design/kwc_datapath.sv @@
module kwc_datapath #(
	parameter int KMER_LEN    = 25,
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kwc_pkg::cmd_t                 cmd,
	output kwc_pkg::sts_t                 sts,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    base_char,
	input  logic [kwc_pkg::SLOT_W-1:0]    slot_index,
	output logic                          kmer_counted,
	output logic                          dropped,
	output logic [kwc_pkg::CODE_W-1:0]    kmer_code,
	output logic [kwc_pkg::COUNT_W-1:0]   kmer_count,
	output logic                          slot_used,
	output logic [kwc_pkg::TOTAL_W-1:0]   distinct_total
);

	localparam int WIN_W = 2 * KMER_LEN;
	localparam int RUN_W = $clog2(KMER_LEN + 1);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int SW    = (kwc_pkg::SLOT_W > CNT_W) ? kwc_pkg::SLOT_W : CNT_W;
	localparam int CW    = kwc_pkg::CODE_W;
	localparam int NW    = kwc_pkg::COUNT_W;
	localparam int TW    = kwc_pkg::TOTAL_W;

	// Table storage
	logic [WIN_W-1:0] key_mem [TABLE_DEPTH];
	logic [NW-1:0]    cnt_mem [TABLE_DEPTH];

	// Window and table control state
	logic [WIN_W-1:0] win_q;
	logic [RUN_W-1:0] run_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] addr_q;
	logic             slot_used_q;
	logic             rd_vld_s1;

	// Read pipeline
	logic [WIN_W-1:0] rd_key_s1;
	logic [NW-1:0]    rd_cnt_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	// Result staging and output beat
	logic          res_counted_q, res_dropped_q, res_used_q;
	logic [CW-1:0] res_code_q;
	logic [NW-1:0] res_count_q;
	logic          counted_q, dropped_q, used_q;
	logic [CW-1:0] code_q;
	logic [NW-1:0] count_q;
	logic [TW-1:0] total_q;

	kwc_pkg::req_t      req;
	kwc_pkg::base_dec_t dec;
	logic [WIN_W+1:0]   win_ext;
	logic [WIN_W-1:0]   win_shift;
	logic [WIN_W+CW-1:0] new_code_ext, rd_code_ext;
	logic [CNT_W+TW-1:0] total_ext;
	logic [SW-1:0]      slot_ext;
	logic [IDX_W-1:0]   rd_addr, wr_idx;
	logic [NW-1:0]      cnt_inc, cnt_wdata;
	logic               run_full_nxt, more, full, issue_now, key_wr, cnt_wr, clear_win;

	// Decode and window shift
	always_comb begin
		req          = kwc_pkg::req_t'(req_type);
		dec          = kwc_pkg::decode_base(base_char);
		win_ext      = {win_q, dec.code};
		win_shift    = win_ext[WIN_W-1:0];
		run_full_nxt = (run_q >= RUN_W'(KMER_LEN - 1));
		clear_win    = (req == kwc_pkg::REQ_EOR) || ((req == kwc_pkg::REQ_ADD) && !dec.ok);
		new_code_ext = {{CW{1'b0}}, win_shift};
		rd_code_ext  = {{CW{1'b0}}, rd_key_s1};
		total_ext    = {{TW{1'b0}}, fill_q};
		slot_ext     = SW'(slot_index);
	end

	// Scan bookkeeping; table slots fill from zero, so fill_q marks the used range
	always_comb begin
		more      = (addr_q < fill_q);
		full      = (fill_q == CNT_W'(TABLE_DEPTH));
		issue_now = cmd.issue && more;
		rd_addr   = cmd.accept ? slot_ext[IDX_W-1:0] : addr_q[IDX_W-1:0];
		cnt_inc   = (&rd_cnt_s1) ? rd_cnt_s1 : rd_cnt_s1 + NW'(1);
		key_wr    = cmd.miss_wr && !full;
		cnt_wr    = cmd.hit_wr || key_wr;
		wr_idx    = cmd.hit_wr ? rd_idx_s1 : fill_q[IDX_W-1:0];
		cnt_wdata = cmd.hit_wr ? cnt_inc : NW'(1);

		sts.scan_go  = (req == kwc_pkg::REQ_ADD) && dec.ok && run_full_nxt;
		sts.slot_go  = (req == kwc_pkg::REQ_READ);
		sts.hit      = rd_vld_s1 && (rd_key_s1 == win_q);
		sts.scan_end = !more && !rd_vld_s1;
	end

	// Key memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (key_wr) key_mem[wr_idx] <= win_q;
		rd_key_s1 <= key_mem[rd_addr];
	end

	// Count memory
	always_ff @(posedge clk) begin
		if (cnt_wr) cnt_mem[wr_idx] <= cnt_wdata;
		rd_cnt_s1 <= cnt_mem[rd_addr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= '0;
			run_q       <= '0;
			fill_q      <= '0;
			addr_q      <= '0;
			slot_used_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			rd_vld_s1 <= issue_now;
			if (cmd.accept) begin
				addr_q      <= '0;
				slot_used_q <= (slot_ext < SW'(fill_q));
				if (clear_win) begin
					win_q <= '0;
					run_q <= '0;
				end else if (req == kwc_pkg::REQ_ADD) begin
					win_q <= win_shift;
					if (run_q != RUN_W'(KMER_LEN)) run_q <= run_q + RUN_W'(1);
				end
			end else if (issue_now) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			if (key_wr) fill_q <= fill_q + CNT_W'(1);
		end
	end

	// Result staging and output register
	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[IDX_W-1:0];
		if (cmd.accept) begin
			res_counted_q <= 1'b0;
			res_dropped_q <= 1'b0;
			res_used_q    <= 1'b0;
			res_count_q   <= '0;
			res_code_q    <= sts.scan_go ? new_code_ext[CW-1:0] : '0;
		end
		if (cmd.hit_wr) begin
			res_counted_q <= 1'b1;
			res_count_q   <= cnt_inc;
		end
		if (cmd.miss_wr) begin
			if (full) begin
				res_dropped_q <= 1'b1;
			end else begin
				res_counted_q <= 1'b1;
				res_count_q   <= NW'(1);
			end
		end
		if (cmd.slot_cap && slot_used_q) begin
			res_used_q  <= 1'b1;
			res_code_q  <= rd_code_ext[CW-1:0];
			res_count_q <= rd_cnt_s1;
		end
		if (cmd.load_out) begin
			counted_q <= res_counted_q;
			dropped_q <= res_dropped_q;
			used_q    <= res_used_q;
			code_q    <= res_code_q;
			count_q   <= res_count_q;
			total_q   <= total_ext[TW-1:0];
		end
	end

	assign kmer_counted   = counted_q;
	assign dropped        = dropped_q;
	assign kmer_code      = code_q;
	assign kmer_count     = count_q;
	assign slot_used      = used_q;
	assign distinct_total = total_q;

endmodule

@@ design/kmer_window_counter_unit.sv @@
// K-mer counter over a stream of DNA bases.
// Input channel (in_valid / in_stall): one beat per request. req_type selects
// add base (base_char), end of read (clears the window) or read table slot
// (slot_index). Output channel (out_valid / out_stall): exactly one result
// beat per request, in request order.
// A base that completes KMER_LEN valid bases triggers a lookup: the table is
// scanned one entry per cycle through the single read port of the key memory.
// From accept to out_valid, a request without lookup goes straight to the
// finish state, a slot read passes through the slot state first, and a
// lookup first scans up to N entries, where N is the number of k-mers
// stored (at most TABLE_DEPTH). The next request is taken only once the
// result is loaded, so the unit finishes one request before the next.
// Slots fill in order from zero and are never freed, so a fill count tracks
// which entries are in use; reset empties the table and the window at once,
// with no clearing pass.
// If the receiver stalls, the finished result waits in the output register
// and the next request is still accepted; its result is held back until the
// output register is free, and in_stall stays high meanwhile.
`include "kmer_window_counter_unit_macros.svh"

module kmer_window_counter_unit #(
	parameter int KMER_LEN    = 25,
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    base_char,
	input  logic [kwc_pkg::SLOT_W-1:0]    slot_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kmer_counted,
	output logic                          dropped,
	output logic [kwc_pkg::CODE_W-1:0]    kmer_code,
	output logic [kwc_pkg::COUNT_W-1:0]   kmer_count,
	output logic                          slot_used,
	output logic [kwc_pkg::TOTAL_W-1:0]   distinct_total
);

	kwc_pkg::cmd_t cmd;
	kwc_pkg::sts_t sts;

	kwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	kwc_datapath #(
		.KMER_LEN    (KMER_LEN),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.req_type       (req_type),
		.base_char      (base_char),
		.slot_index     (slot_index),
		.kmer_counted   (kmer_counted),
		.dropped        (dropped),
		.kmer_code      (kmer_code),
		.kmer_count     (kmer_count),
		.slot_used      (slot_used),
		.distinct_total (distinct_total)
	);

	// One request at a time
	`KWC_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall)
	// A new result never overwrites one still waiting
	`KWC_ASSERT_IMP(a_load_free, cmd.load_out, !(out_valid && out_stall))
	// Controller issues at most one command per cycle
	`KWC_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd))
	// A hit count update always follows an issued table read
	`KWC_ASSERT_IMP(a_hit_after_read, cmd.hit_wr, $past(cmd.issue))

endmodule
